@@ sv/assert_macros.svh @@
// assertion macros shared by the goal frame move profile rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define GFMP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define GFMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/gfmp_pkg.sv @@
// types, constants and helper functions for the goal frame move profile
// no dependencies; imported by every module of the block
package gfmp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int VW = 30;
  localparam int ZW = 25;
  localparam int MAG_W = 28;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] zang_t;

  localparam zang_t DEG180 = 25'sd4608000;
  localparam zang_t DEG90 = 25'sd2304000;

  typedef enum logic [2:0] {
    CFG_ALLIANCE = 3'd0,
    CFG_REACH    = 3'd1,
    CFG_RAMP     = 3'd2,
    CFG_MIN      = 3'd3,
    CFG_MAX      = 3'd4,
    CFG_EFFORT   = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    CM_ROTATE = 1'b0,
    CM_VECTOR = 1'b1
  } cmode_t;

  typedef struct packed {
    logic               yellow_seen;
    logic signed [15:0] yellow_bearing;
    logic [15:0]        yellow_range;
    logic               blue_seen;
    logic signed [15:0] blue_bearing;
    logic [15:0]        blue_range;
    logic signed [15:0] target_angle;
    logic [15:0]        target_range;
    logic signed [15:0] target_heading;
  } in_t;

  typedef struct packed {
    logic               profile_valid;
    logic signed [15:0] drive_bearing;
    logic [14:0]        drive_speed;
    logic signed [15:0] turn_rate;
    logic [15:0]        goal_separation;
    logic signed [15:0] front_angle;
  } out_t;

  typedef struct packed {
    logic        yellow_alliance;
    logic [15:0] reach_distance;
    logic [15:0] ramp_range;
    logic [14:0] min_speed;
    logic [14:0] max_speed;
    logic [14:0] rotation_effort;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] yellow_bearing;
    logic [15:0]        yellow_range;
    logic signed [15:0] blue_bearing;
    logic [15:0]        blue_range;
    logic signed [15:0] target_angle;
    logic [15:0]        target_range;
    logic signed [15:0] target_heading;
  } item_t;

  typedef struct packed {
    logic               start;
    cmode_t             mode;
    vec_t               x;
    vec_t               y;
    logic signed [16:0] ang;
    logic [15:0]        range;
  } cord_req_t;

  typedef struct packed {
    logic               done;
    vec_t               x;
    vec_t               y;
    logic signed [15:0] ang;
    logic [MAG_W-1:0]   mag;
  } cord_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  // arctangent of 2^-i in 1/25600 degree
  function automatic logic [20:0] atan_at(input logic [4:0] idx);
    logic [20:0] v;
    case (idx)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      5'd20: v = 21'd1;
      5'd21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

  // one wrap step into -18000..18000 hundredths of a degree
  function automatic logic signed [15:0] wrap_cd(input logic signed [17:0] a);
    logic signed [17:0] w;
    w = a;
    if (w > 18'sd18000) begin
      w = w - 18'sd36000;
    end else if (w < -18'sd18000) begin
      w = w + 18'sd36000;
    end
    return w[15:0];
  endfunction

endpackage

@@ sv/gfmp_front.sv @@
// front end: configuration registers, input acceptance and classification
// depends on gfmp_pkg
module gfmp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  gfmp_pkg::in_t   in_item,
  input  logic            q_full,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output logic            push,
  output gfmp_pkg::item_t push_item,
  output gfmp_pkg::cfg_t  cfg
);
  import gfmp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yellow_alliance <= 1'b0;
      cfg_r.reach_distance  <= 16'd80;
      cfg_r.ramp_range      <= 16'd800;
      cfg_r.min_speed       <= 15'd6554;
      cfg_r.max_speed       <= 15'd32767;
      cfg_r.rotation_effort <= 15'd4500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALLIANCE: cfg_r.yellow_alliance <= cfg_data[0];
        CFG_REACH:    cfg_r.reach_distance  <= cfg_data;
        CFG_RAMP:     cfg_r.ramp_range      <= cfg_data;
        CFG_MIN:      cfg_r.min_speed       <= cfg_data[14:0];
        CFG_MAX:      cfg_r.max_speed       <= cfg_data[14:0];
        CFG_EFFORT:   cfg_r.rotation_effort <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
  assign push = start && !q_full;

  always_comb begin
    push_item.valid          = in_item.yellow_seen && in_item.blue_seen;
    push_item.yellow_bearing = in_item.yellow_bearing;
    push_item.yellow_range   = in_item.yellow_range;
    push_item.blue_bearing   = in_item.blue_bearing;
    push_item.blue_range     = in_item.blue_range;
    push_item.target_angle   = in_item.target_angle;
    push_item.target_range   = in_item.target_range;
    push_item.target_heading = in_item.target_heading;
  end

endmodule

@@ sv/gfmp_queue.sv @@
// short item queue between the front end and the back end
// depends on gfmp_pkg and assert_macros.svh
`include "assert_macros.svh"
module gfmp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gfmp_pkg::item_t push_item,
  input  logic            pop,
  output gfmp_pkg::item_t head_item,
  output logic            full,
  output logic            empty
);
  import gfmp_pkg::*;

  item_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head_item = entries_r[rd_ptr_r];
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);

  `GFMP_ASSERT(a_q_no_overflow, !(push && full && !pop))
  `GFMP_ASSERT(a_q_no_underflow, !(pop && empty))

endmodule

@@ sv/gfmp_cordic.sv @@
// shared cordic unit: polar to cartesian (rotation) and cartesian to polar
// (vectoring) with gain compensation; depends on gfmp_pkg and assert_macros.svh
`include "assert_macros.svh"
module gfmp_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gfmp_pkg::cord_req_t   req,
  output gfmp_pkg::cord_rsp_t   rsp
);
  import gfmp_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_PREP = 4'b0010,
    C_ITER = 4'b0100,
    C_POST = 4'b1000
  } cstate_t;

  cstate_t            state_r;
  cmode_t             mode_r;
  vec_t               x_r;
  vec_t               y_r;
  zang_t              z_r;
  logic [STEP_W-1:0]  step_r;
  logic               zero_r;
  logic signed [15:0] ang_in_r;
  logic [15:0]        range_r;
  logic               done_r;
  logic signed [15:0] ang_r;
  logic [MAG_W-1:0]   mag_r;

  // rotation setup
  logic [45:0]        rprod;
  logic [46:0]        rsum;
  logic [23:0]        r0;
  vec_t               r0_v;
  zang_t              za;
  // iteration
  vec_t               sx;
  vec_t               sy;
  zang_t              at_v;
  logic               dpos;
  // post processing
  logic [VW-2:0]      xm;
  logic [VW+28:0]     mprod;
  logic [VW+29:0]     msum;
  zang_t              zabs;
  logic [ZW-1:0]      zt;
  logic [17:0]        zs;

  always_comb begin
    rprod = range_r * KINV_Q30;
    rsum  = {1'b0, rprod} + 47'd2097152;
    r0    = rsum[45:22];
    r0_v  = {{(VW-24){1'b0}}, r0};
    za    = {{(ZW-24){ang_in_r[15]}}, ang_in_r, 8'b0};

    sx   = y_r >>> step_r;
    sy   = x_r >>> step_r;
    at_v = {{(ZW-21){1'b0}}, atan_at(5'(step_r))};
    dpos = (mode_r == CM_ROTATE) ? (z_r >= 0) : !(y_r > 0);

    xm    = x_r[VW-1] ? '0 : x_r[VW-2:0];
    mprod = xm * KINV_Q30;
    msum  = {1'b0, mprod} + (VW+30)'(30'd536870912);
    zabs  = (z_r >= 0) ? z_r : -z_r;
    zt    = zabs + ZW'(128);
    zs    = (z_r >= 0) ? {1'b0, zt[ZW-1:8]} : -{1'b0, zt[ZW-1:8]};
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        if (req.start) begin
          mode_r   <= req.mode;
          x_r      <= req.x;
          y_r      <= req.y;
          ang_in_r <= wrap_cd({req.ang[16], req.ang});
          range_r  <= req.range;
        end
      end
      C_PREP: begin
        step_r <= '0;
        if (mode_r == CM_ROTATE) begin
          y_r <= '0;
          if (za > DEG90) begin
            z_r <= za - DEG180;
            x_r <= -r0_v;
          end else if (za < -DEG90) begin
            z_r <= za + DEG180;
            x_r <= -r0_v;
          end else begin
            z_r <= za;
            x_r <= r0_v;
          end
        end else begin
          zero_r <= (x_r == '0) && (y_r == '0);
          if (x_r < 0) begin
            z_r <= (y_r >= 0) ? DEG180 : -DEG180;
            x_r <= -x_r;
            y_r <= -y_r;
          end else begin
            z_r <= '0;
          end
        end
      end
      C_ITER: begin
        step_r <= step_r + 1'b1;
        if (dpos) begin
          x_r <= x_r - sx;
          y_r <= y_r + sy;
          z_r <= z_r - at_v;
        end else begin
          x_r <= x_r + sx;
          y_r <= y_r - sy;
          z_r <= z_r + at_v;
        end
      end
      C_POST: begin
        if (zero_r) begin
          ang_r <= '0;
          mag_r <= '0;
        end else begin
          ang_r <= wrap_cd(zs);
          mag_r <= msum[30 +: MAG_W];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: if (req.start) state_r <= C_PREP;
        C_PREP: state_r <= C_ITER;
        C_ITER: begin
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
            state_r <= C_POST;
          end
        end
        C_POST: begin
          state_r <= C_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;
  assign rsp.ang  = ang_r;
  assign rsp.mag  = mag_r;

  `GFMP_ASSERT_IMPL(a_cord_start_idle, req.start, state_r == C_IDLE)

endmodule

@@ sv/gfmp_div.sv @@
// restoring divider, one quotient bit per cycle, unsigned
// depends on gfmp_pkg
module gfmp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gfmp_pkg::div_req_t  req,
  output gfmp_pkg::div_rsp_t  rsp
);
  import gfmp_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   shifted;
  logic              ge;

  always_comb begin
    shifted = {rem_r, num_r[DIV_NW-1]};
    ge      = (shifted >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], ge};
      rem_r <= ge ? DIV_DW'(shifted - {1'b0, den_r}) : shifted[DIV_DW-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

@@ sv/gfmp_back.sv @@
// back end sequencer: field frame, target bearing, speed ramp and turn rate
// depends on gfmp_pkg, gfmp_cordic, gfmp_div and assert_macros.svh
`include "assert_macros.svh"
module gfmp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  gfmp_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  gfmp_pkg::item_t q_item,
  output logic            pop,
  output logic            out_strobe,
  output gfmp_pkg::out_t  out_item
);
  import gfmp_pkg::*;

  typedef enum logic [7:0] {
    B_IDLE   = 8'b00000001,
    B_CSTART = 8'b00000010,
    B_CWAIT  = 8'b00000100,
    B_SPEED  = 8'b00001000,
    B_SWAIT  = 8'b00010000,
    B_TURN   = 8'b00100000,
    B_TWAIT  = 8'b01000000,
    B_EMIT   = 8'b10000000
  } bstate_t;

  typedef enum logic [2:0] {
    OP_ROT_Y     = 3'd0,
    OP_ROT_B     = 3'd1,
    OP_VEC_FRONT = 3'd2,
    OP_VEC_SEP   = 3'd3,
    OP_ROT_T     = 3'd4,
    OP_VEC_T     = 3'd5
  } op_t;

  bstate_t            state_r;
  op_t                op_r;
  item_t              item_r;
  vec_t               ybx_r, yby_r, bbx_r, bby_r, atx_r, aty_r;
  logic signed [15:0] front_r;
  logic [15:0]        sep_r;
  logic signed [15:0] bearing_r;
  logic [19:0]        dist_r;
  logic [14:0]        speed_r;
  logic signed [15:0] turn_r;
  logic               neg_r;
  logic               out_strobe_r;
  out_t               out_item_r;

  cord_req_t          cord_req;
  cord_rsp_t          cord_rsp;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic signed [16:0] fsum;
  logic signed [15:0] fwd;
  logic signed [15:0] err;
  logic [MAG_W:0]     ssum;
  logic [20:0]        sval;
  logic [MAG_W:0]     dsum;
  logic signed [20:0] remain;
  logic               rem_zero;
  logic               rem_full;
  logic signed [15:0] sdiff;
  logic signed [32:0] sprod;
  logic [32:0]        sabs;
  logic [15:0]        eabs;
  logic [29:0]        tprod;
  logic [16:0]        q17;
  logic [16:0]        sres;
  logic [14:0]        tsat;

  gfmp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  gfmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    fsum = {front_r[15], front_r} + 17'sd18000;
    fwd  = cfg.yellow_alliance ? wrap_cd({fsum[16], fsum}) : front_r;
    err  = wrap_cd({{2{item_r.target_heading[15]}}, item_r.target_heading}
                   + {{2{fwd[15]}}, fwd});

    ssum = {1'b0, cord_rsp.mag} + (MAG_W+1)'(128);
    sval = 21'(ssum[MAG_W:8]);
    dsum = {1'b0, cord_rsp.mag} + (MAG_W+1)'(256);

    remain   = $signed({1'b0, dist_r}) - $signed({5'b0, cfg.reach_distance});
    rem_zero = (remain <= 21'sd0);
    rem_full = (remain >= $signed({5'b0, cfg.ramp_range}));
    sdiff    = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});
    sprod    = $signed({1'b0, remain[15:0]}) * sdiff;
    sabs     = sprod[32] ? -sprod : sprod;

    eabs  = err[15] ? -err : err;
    tprod = eabs[14:0] * 15'd32767;

    q17  = {1'b0, div_rsp.quo[15:0]};
    sres = {2'b0, cfg.min_speed} + (neg_r ? -q17 : q17);
    tsat = (div_rsp.quo > DIV_NW'(32767)) ? 15'd32767 : div_rsp.quo[14:0];
  end

  always_comb begin
    cord_req.start = (state_r == B_CSTART);
    cord_req.mode  = CM_ROTATE;
    cord_req.x     = '0;
    cord_req.y     = '0;
    cord_req.ang   = '0;
    cord_req.range = '0;
    case (op_r)
      OP_ROT_Y: begin
        cord_req.ang   = {item_r.yellow_bearing[15], item_r.yellow_bearing};
        cord_req.range = item_r.yellow_range;
      end
      OP_ROT_B: begin
        cord_req.ang   = {item_r.blue_bearing[15], item_r.blue_bearing};
        cord_req.range = item_r.blue_range;
      end
      OP_VEC_FRONT: begin
        cord_req.mode = CM_VECTOR;
        cord_req.x    = ybx_r - bbx_r;
        cord_req.y    = yby_r - bby_r;
      end
      OP_VEC_SEP: begin
        cord_req.mode = CM_VECTOR;
        cord_req.x    = bbx_r - ybx_r;
        cord_req.y    = bby_r - yby_r;
      end
      OP_ROT_T: begin
        cord_req.ang   = {fwd[15], fwd}
                         + {item_r.target_angle[15], item_r.target_angle};
        cord_req.range = item_r.target_range;
      end
      OP_VEC_T: begin
        cord_req.mode = CM_VECTOR;
        cord_req.x    = ybx_r + bbx_r + (atx_r <<< 1);
        cord_req.y    = yby_r + bby_r + (aty_r <<< 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    if (state_r == B_SPEED) begin
      div_req.start = !rem_zero && !rem_full;
      div_req.num   = DIV_NW'(sabs) + DIV_NW'(cfg.ramp_range[15:1]);
      div_req.den   = cfg.ramp_range;
    end else if (state_r == B_TURN) begin
      div_req.start = (cfg.rotation_effort != '0);
      div_req.num   = DIV_NW'(tprod) + DIV_NW'(cfg.rotation_effort[14:1]);
      div_req.den   = {1'b0, cfg.rotation_effort};
    end
  end

  assign pop = (state_r == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          item_r <= q_item;
          op_r   <= OP_ROT_Y;
        end
      end
      B_CWAIT: begin
        if (cord_rsp.done) begin
          case (op_r)
            OP_ROT_Y: begin
              ybx_r <= cord_rsp.x;
              yby_r <= cord_rsp.y;
            end
            OP_ROT_B: begin
              bbx_r <= cord_rsp.x;
              bby_r <= cord_rsp.y;
            end
            OP_VEC_FRONT: front_r <= cord_rsp.ang;
            OP_VEC_SEP: sep_r <= (sval > 21'd65535) ? 16'hFFFF : sval[15:0];
            OP_ROT_T: begin
              atx_r <= cord_rsp.x;
              aty_r <= cord_rsp.y;
            end
            OP_VEC_T: begin
              bearing_r <= cord_rsp.ang;
              dist_r    <= 20'(dsum[MAG_W:9]);
            end
            default: ;
          endcase
          if (op_r != OP_VEC_T) begin
            op_r <= op_t'(op_r + 1'b1);
          end
        end
      end
      B_SPEED: begin
        neg_r <= sprod[32];
        if (rem_zero) begin
          speed_r <= '0;
        end else if (rem_full) begin
          speed_r <= cfg.max_speed;
        end
      end
      B_SWAIT: if (div_rsp.done) speed_r <= sres[14:0];
      B_TURN: begin
        neg_r <= err[15];
        if (cfg.rotation_effort == '0) begin
          if (err > 16'sd0) begin
            turn_r <= 16'sd32767;
          end else if (err < 16'sd0) begin
            turn_r <= -16'sd32767;
          end else begin
            turn_r <= '0;
          end
        end
      end
      B_TWAIT: begin
        if (div_rsp.done) begin
          turn_r <= neg_r ? -$signed({1'b0, tsat}) : $signed({1'b0, tsat});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_item.valid) begin
              state_r <= B_CSTART;
            end else begin
              out_strobe_r <= 1'b1;
              out_item_r   <= '0;
            end
          end
        end
        B_CSTART: state_r <= B_CWAIT;
        B_CWAIT: begin
          if (cord_rsp.done) begin
            state_r <= (op_r == OP_VEC_T) ? B_SPEED : B_CSTART;
          end
        end
        B_SPEED: state_r <= (rem_zero || rem_full) ? B_TURN : B_SWAIT;
        B_SWAIT: if (div_rsp.done) state_r <= B_TURN;
        B_TURN:  state_r <= (cfg.rotation_effort == '0) ? B_EMIT : B_TWAIT;
        B_TWAIT: if (div_rsp.done) state_r <= B_EMIT;
        B_EMIT: begin
          state_r                    <= B_IDLE;
          out_strobe_r               <= 1'b1;
          out_item_r.profile_valid   <= 1'b1;
          out_item_r.drive_bearing   <= bearing_r;
          out_item_r.drive_speed     <= speed_r;
          out_item_r.turn_rate       <= turn_r;
          out_item_r.goal_separation <= sep_r;
          out_item_r.front_angle     <= front_r;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `GFMP_ASSERT_IMPL(a_invalid_zero, out_strobe_r && !out_item_r.profile_valid,
                    out_item_r == '0)
  `GFMP_ASSERT_IMPL(a_div_done_wait, div_rsp.done,
                    state_r == B_SWAIT || state_r == B_TWAIT)
  `GFMP_ASSERT_IMPL(a_cord_done_wait, cord_rsp.done, state_r == B_CWAIT)

endmodule

@@ sv/goal_frame_move_profile.sv @@
// goal frame move profile: drive bearing, speed and turn rate from goal sightings
// top level; depends on gfmp_pkg, gfmp_front, gfmp_queue and gfmp_back
//
// usage: drive in_item and raise start; the beat is taken at an edge where
// start is high and busy is low. busy rises only while the two-entry queue
// between the front end and the back end is full.
// each beat yields one result, shown on out_item for one cycle with out_strobe;
// the receiver cannot stall, so results are never held back.
// a beat with a goal missing returns an all-zero result through the queue entry
// and the output register (plus the wait for earlier beats in the queue).
// a beat with both goals runs six operations in the shared cordic unit and up to
// two divisions in the shared serial divider; that pair sets the sustained rate.
// configuration: cfg_we, cfg_index, cfg_data write one register per edge
// (0 alliance, 1 reach, 2 ramp, 3 min speed, 4 max speed, 5 rotation effort);
// other indexes are ignored. write only while the block is idle.
// reset (rst_n low, synchronous) empties the queue, aborts work in flight and
// restores the register defaults.
module goal_frame_move_profile (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gfmp_pkg::in_t  in_item,
  output logic           out_strobe,
  output gfmp_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import gfmp_pkg::*;

  logic  push;
  item_t push_item;
  item_t head_item;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  cfg_t  cfg;

  gfmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .q_full    (q_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  gfmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  gfmp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_item     (head_item),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  assign busy = q_full;

endmodule

@@ tb/goal_frame_move_profile_tb.sv @@
// testbench for goal_frame_move_profile: directed table then random beats,
// every result checked against a fixed-point cordic predictor or a typed all-zero row
// depends on gfmp_pkg and the goal_frame_move_profile rtl
module goal_frame_move_profile_tb;
  import gfmp_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam longint HALF_TURN = 4608000;
  localparam longint QUARTER_TURN = 2304000;
  localparam longint GAIN_INV = 652032874;
  localparam logic [2:0] NO_REG_A = 3'd6;
  localparam logic [2:0] NO_REG_B = 3'd7;
  localparam longint ARC_TAB [24] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0
  };

  typedef struct packed {
    logic typed;
    in_t  stim;
    out_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_item;
  logic out_strobe;
  out_t out_item;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  cfg_t prof_cfg;
  out_t expected_profiles[$];
  out_t want;
  int miss_count;
  int cycles;
  row_t dir_tab[14];
  cfg_t cfg_sets[9];

  goal_frame_move_profile DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint wrap_hd(longint a);
    while (a > 18000) a -= 36000;
    while (a < -18000) a += 36000;
    return a;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic void rotate_to_xy(longint ang, longint rng,
                                       output longint ox, output longint oy);
    longint z, r0, x, y, dx, dy;
    z = wrap_hd(ang) * 256;
    r0 = (rng * 256 * GAIN_INV + (longint'(1) << 29)) >>> 30;
    x = r0;
    y = 0;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN;
      x = -r0;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      x = -r0;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end else begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic void vector_to_polar(longint x, longint y,
                                          output longint ang, output longint mag);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end
    end
    if (x < 0) x = 0;
    ang = wrap_hd(round_div(z, 256));
    mag = (x * GAIN_INV + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic out_t predict_profile(in_t b);
    out_t r;
    longint yx, yy, bx, by, ax, ay, tx, ty, front, fwd, head, ang, mag;
    longint sep, bearing, tgt_dist, remaining, speed, err, rot;
    r = '0;
    if (!b.yellow_seen || !b.blue_seen) return r;
    rotate_to_xy(longint'(b.yellow_bearing), longint'(b.yellow_range), yx, yy);
    rotate_to_xy(longint'(b.blue_bearing), longint'(b.blue_range), bx, by);
    vector_to_polar(yx - bx, yy - by, front, mag);
    vector_to_polar(bx - yx, by - yy, ang, mag);
    sep = (mag + 128) / 256;
    if (sep > 65535) sep = 65535;
    fwd = prof_cfg.yellow_alliance ? wrap_hd(front + 18000) : front;
    head = wrap_hd(-fwd);
    rotate_to_xy(fwd + longint'(b.target_angle), longint'(b.target_range), ax, ay);
    tx = yx + bx + 2 * ax;
    ty = yy + by + 2 * ay;
    vector_to_polar(tx, ty, bearing, mag);
    tgt_dist = (mag + 256) / 512;
    remaining = tgt_dist - longint'(prof_cfg.reach_distance);
    if (remaining <= 0) speed = 0;
    else if (remaining >= longint'(prof_cfg.ramp_range)) speed = prof_cfg.max_speed;
    else speed = longint'(prof_cfg.min_speed) + round_div(remaining *
      (longint'(prof_cfg.max_speed) - longint'(prof_cfg.min_speed)),
      longint'(prof_cfg.ramp_range));
    err = wrap_hd(longint'(b.target_heading) - head);
    if (prof_cfg.rotation_effort == 0) begin
      rot = (err > 0) ? 32767 : ((err < 0) ? -32767 : 0);
    end else begin
      rot = round_div(err * 32767, longint'(prof_cfg.rotation_effort));
      if (rot > 32767) rot = 32767;
      if (rot < -32767) rot = -32767;
    end
    r.profile_valid = 1'b1;
    r.drive_bearing = bearing[15:0];
    r.drive_speed = speed[14:0];
    r.turn_rate = rot[15:0];
    r.goal_separation = sep[15:0];
    r.front_angle = front[15:0];
    return r;
  endfunction

  function automatic in_t pack_beat(bit ys, int yb, int yr, bit bs, int bb, int br,
                                    int ta, int tr, int th);
    in_t b;
    b.yellow_seen = ys;
    b.yellow_bearing = yb[15:0];
    b.yellow_range = yr[15:0];
    b.blue_seen = bs;
    b.blue_bearing = bb[15:0];
    b.blue_range = br[15:0];
    b.target_angle = ta[15:0];
    b.target_range = tr[15:0];
    b.target_heading = th[15:0];
    return b;
  endfunction

  function automatic int rand_angle();
    if ($urandom_range(0, 99) < 80) return int'($urandom_range(0, 36000)) - 18000;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_dist();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return $urandom_range(0, 4000);
    if (k < 90) return $urandom_range(0, 20000);
    return $urandom_range(0, 65535);
  endfunction

  function automatic in_t rand_beat();
    int k;
    k = $urandom_range(0, 99);
    return pack_beat(k >= 6, rand_angle(), rand_dist(), k < 6 || k >= 12,
                     rand_angle(), rand_dist(), rand_angle(), rand_dist(),
                     rand_angle());
  endfunction

  task automatic note_miss(string what, out_t e, out_t g);
    miss_count++;
    if (miss_count <= 10) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  exp valid %0d bear %0d speed %0d turn %0d sep %0d front %0d",
               e.profile_valid, e.drive_bearing, e.drive_speed, e.turn_rate,
               e.goal_separation, e.front_angle);
      $display("  got valid %0d bear %0d speed %0d turn %0d sep %0d front %0d",
               g.profile_valid, g.drive_bearing, g.drive_speed, g.turn_rate,
               g.goal_separation, g.front_angle);
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_profiles.size() == 0) begin
        note_miss("unexpected result", '0, out_item);
      end else begin
        want = expected_profiles.pop_front();
        if (out_item !== want) note_miss("result mismatch", want, out_item);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // called right after an edge; leaves start high on return
  task automatic send_beat(in_t b, int idle_pct);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic drain_block();
    while (expected_profiles.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_cfg(cfg_t c);
    logic [15:0] junk;
    start <= 1'b0;
    @(posedge clk);
    drain_block();
    junk = $urandom_range(0, 65535);
    write_reg(CFG_ALLIANCE, {junk[15:1], c.yellow_alliance});
    write_reg(CFG_REACH, c.reach_distance);
    write_reg(CFG_RAMP, c.ramp_range);
    write_reg(CFG_MIN, {junk[0], c.min_speed});
    write_reg(CFG_MAX, {junk[1], c.max_speed});
    write_reg(CFG_EFFORT, {junk[2], c.rotation_effort});
    write_reg(NO_REG_A, 16'hffff);
    write_reg(NO_REG_B, junk);
    cfg_we <= 1'b0;
    prof_cfg = c;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    miss_count = 0;
    prof_cfg = '{1'b0, 16'd80, 16'd800, 15'd6554, 15'd32767, 15'd4500};

    dir_tab[0] = '{1'b1, pack_beat(0, 1000, 500, 1, -2000, 700, 0, 100, 0), '0};
    dir_tab[1] = '{1'b1, pack_beat(1, 1000, 500, 0, -2000, 700, 0, 100, 0), '0};
    dir_tab[2] = '{1'b1, pack_beat(0, -1, 65535, 0, -1, 65535, -1, 65535, -1), '0};
    dir_tab[3] = '{1'b0, pack_beat(1, 4500, 1200, 1, 4500, 1200, 0, 0, 0), '0};
    dir_tab[4] = '{1'b0, pack_beat(1, 0, 0, 1, 0, 0, 9000, 300, 18000), '0};
    dir_tab[5] = '{1'b0, pack_beat(1, 18000, 65535, 1, -18000, 65535, 18000, 65535,
                                   -18000), '0};
    dir_tab[6] = '{1'b0, pack_beat(1, -32768, 3000, 1, 32767, 2000, -32768, 400,
                                   32767), '0};
    dir_tab[7] = '{1'b0, pack_beat(1, 0, 1600, 1, 18000, 1600, 0, 0, 0), '0};
    dir_tab[8] = '{1'b0, pack_beat(1, 9000, 2000, 1, -9000, 2000, 0, 0, 9000), '0};
    dir_tab[9] = '{1'b0, pack_beat(1, 0, 3000, 1, 18000, 3000, 0, 20000, -9000), '0};
    dir_tab[10] = '{1'b0, pack_beat(1, 3000, 2500, 1, -15000, 2500, 4500, 500, 1),
                    '0};
    dir_tab[11] = '{1'b0, pack_beat(1, -9000, 800, 1, 9000, 900, -18000, 65535, 12345),
                    '0};
    dir_tab[12] = '{1'b0, pack_beat(1, 17999, 1, 1, -17999, 65534, 1, 1, -1), '0};
    dir_tab[13] = '{1'b1, pack_beat(1, 5000, 900, 0, 5000, 900, 5000, 900, 5000), '0};

    cfg_sets[0] = '{1'b1, 16'd0, 16'd1, 15'd0, 15'd32767, 15'd1};
    cfg_sets[1] = '{1'b0, 16'd65535, 16'd65535, 15'd32767, 15'd0, 15'd18000};
    cfg_sets[2] = '{1'b1, 16'd80, 16'd0, 15'd100, 15'd30000, 15'd0};
    cfg_sets[3] = '{1'b0, 16'd200, 16'd2000, 15'd32767, 15'd32767, 15'd32767};
    for (int s = 4; s < 9; s++) begin
      cfg_sets[s].yellow_alliance = $urandom_range(0, 1);
      cfg_sets[s].reach_distance = $urandom_range(0, 400);
      cfg_sets[s].ramp_range = $urandom_range(1, 6000);
      cfg_sets[s].min_speed = $urandom_range(0, 16000);
      cfg_sets[s].max_speed = $urandom_range(16000, 32767);
      cfg_sets[s].rotation_effort = $urandom_range(1, 18000);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults after reset
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].stim, 0);
      expected_profiles.push_back(dir_tab[i].typed ? dir_tab[i].res
                                                   : predict_profile(dir_tab[i].stim));
    end

    for (int s = 0; s < 9; s++) begin
      apply_cfg(cfg_sets[s]);
      for (int n = 0; n < 160; n++) begin
        in_t b;
        b = rand_beat();
        send_beat(b, (s < 3) ? 25 : ((s < 6) ? 86 : 0));
        expected_profiles.push_back(predict_profile(b));
      end
    end
    start <= 1'b0;

    while (expected_profiles.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (miss_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
